FILE: src/mpc_pkg.sv
// Package for the Mandelbrot pixel classifier: widths, reset values,
// register indexes and the token that circulates through the iteration ring.
// No dependencies.
`default_nettype none

package mpc_pkg;

    // Field widths fixed by the interface
    localparam int PIX_W    = 10;
    localparam int COORD_W  = 32;
    localparam int SCALE_W  = 20;
    localparam int ITER_W   = 8;
    localparam int CFG_IDX_W = 3;

    // Default geometry and number format
    localparam int FRAME_WIDTH_DEF   = 1024;
    localparam int FRAME_HEIGHT_DEF  = 768;
    localparam int FRACTION_BITS_DEF = 28;

    // Number of iteration cells in the ring
    localparam int NUM_CELLS = 2;

    // Pixel position is scaled to 1/1024 of the frame, then centred
    localparam int COORD_SHIFT = 10;
    localparam logic [COORD_W-1:0] COORD_BIAS = COORD_W'(1) << 9;

    // Reciprocal precision for the divide by frame size
    localparam int RECIP_SHIFT = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_W   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_H   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd4;

    // Register reset values
    localparam logic [COORD_W-1:0] CENTER_X_RST = -32'sd247586821;
    localparam logic [COORD_W-1:0] CENTER_Y_RST = 32'sd83284740;
    localparam logic [SCALE_W-1:0] SCALE_W_RST  = 20'd786432;
    localparam logic [SCALE_W-1:0] SCALE_H_RST  = 20'd524288;
    localparam logic [ITER_W-1:0]  MAX_ITER_RST = 8'd50;

    // Pixel colours
    localparam logic COLOR_BLACK = 1'b0;
    localparam logic COLOR_WHITE = 1'b1;

    // One point in flight: z, c and the rounds still to run
    typedef struct packed {
        logic               valid;
        logic               done;
        logic               color;
        logic [ITER_W-1:0]  rem;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
    } t_token;

endpackage

`default_nettype wire

FILE: src/mpc_coord.sv
// Start point unit: maps a pixel position to one coordinate of c.
// c = center + ((coord << 10) / SIZE - 512) * scale, 32-bit wrap.
// Depends on mpc_pkg.
`default_nettype none

module mpc_coord import mpc_pkg::*; #(
    parameter int SIZE = FRAME_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [PIX_W-1:0]   i_coord,
    input  wire logic [COORD_W-1:0] i_center,
    input  wire logic [SCALE_W-1:0] i_scale,
    output logic                    o_valid,
    output logic [COORD_W-1:0]      o_c
);

    localparam int N_W = PIX_W + COORD_SHIFT;
    localparam int P_W = N_W + RECIP_SHIFT;
    localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SHIFT) / SIZE;
    localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'(RECIP_FULL);
    localparam logic [N_W-1:0] SIZE_N = N_W'(SIZE);

    logic [3:0]         r_v;
    logic [N_W-1:0]     r_n;
    logic [N_W-1:0]     r_q0;
    logic [N_W-1:0]     r_q;
    logic [COORD_W-1:0] r_off;

    logic [P_W-1:0]     w_prod;
    logic [N_W-1:0]     w_rem;
    logic [COORD_W-1:0] w_off;

    // quotient estimate: low by at most one
    assign w_prod = P_W'(r_n) * P_W'(RECIP);
    // remainder of the estimate stays below twice the frame size
    assign w_rem  = r_n - r_q0 * SIZE_N;
    assign w_off  = (COORD_W'(r_q) - COORD_BIAS) * COORD_W'(i_scale);

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_start};
        end
    end

    // data stages
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n <= {i_coord, COORD_SHIFT'(0)};
        end
        r_q0  <= w_prod[RECIP_SHIFT +: N_W];
        r_q   <= r_q0 + N_W'(w_rem >= SIZE_N);
        r_off <= w_off;
    end

    assign o_valid = r_v[3];
    assign o_c     = i_center + r_off;

endmodule

`default_nettype wire

FILE: src/mpc_cell.sv
// Iteration cell: one round of z = z*z + c with the bound test, in two
// registered steps (products, then add and test). Depends on mpc_pkg.
`default_nettype none

module mpc_cell import mpc_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_token i_tok,
    output t_token      o_tok
);

    localparam int FULL_W = 2 * COORD_W;
    localparam int PROD_W = FULL_W - FRACTION_BITS;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [SUM_W-1:0] LIMIT = SUM_W'(4) << FRACTION_BITS;

    t_token r_tok1;
    t_token r_tok;
    t_token n_tok;

    logic signed [PROD_W-1:0] r_xx;
    logic signed [PROD_W-1:0] r_yy;
    logic signed [PROD_W-1:0] r_xy;

    logic signed [FULL_W-1:0] w_xx_full;
    logic signed [FULL_W-1:0] w_yy_full;
    logic signed [FULL_W-1:0] w_xy_full;
    logic [SUM_W-1:0]         w_mag;
    logic                     w_escape;
    logic [COORD_W-1:0]       w_x_new;
    logic [COORD_W-1:0]       w_y_new;

    // step one: the three products
    assign w_xx_full = $signed(i_tok.x) * $signed(i_tok.x);
    assign w_yy_full = $signed(i_tok.y) * $signed(i_tok.y);
    assign w_xy_full = $signed(i_tok.x) * $signed(i_tok.y);

    always_ff @(posedge i_clk) begin
        r_xx <= PROD_W'(w_xx_full >>> FRACTION_BITS);
        r_yy <= PROD_W'(w_yy_full >>> FRACTION_BITS);
        r_xy <= PROD_W'(w_xy_full >>> FRACTION_BITS);
    end

    // step two: bound test and update
    assign w_mag    = SUM_W'(r_xx) + SUM_W'(r_yy);
    assign w_escape = w_mag > LIMIT;
    assign w_x_new  = r_xx[COORD_W-1:0] - r_yy[COORD_W-1:0] + r_tok1.cx;
    assign w_y_new  = {r_xy[COORD_W-2:0], 1'b0} + r_tok1.cy;

    always_comb begin
        n_tok = r_tok1;
        if (r_tok1.valid && !r_tok1.done) begin
            priority if (r_tok1.rem == '0) begin
                n_tok.done  = 1'b1;
                n_tok.color = COLOR_BLACK;
            end else if (w_escape) begin
                n_tok.done  = 1'b1;
                n_tok.color = COLOR_WHITE;
            end else begin
                n_tok.x   = w_x_new;
                n_tok.y   = w_y_new;
                n_tok.rem = r_tok1.rem - 1'b1;
            end
        end
    end

    // token registers; only the valid bits need reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok1.valid <= 1'b0;
            r_tok.valid  <= 1'b0;
        end else begin
            r_tok1 <= i_tok;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

FILE: src/mandelbrot_pixel_classifier.sv
// Mandelbrot pixel classifier, top level. Depends on mpc_pkg, mpc_coord, mpc_cell.
// A pixel passes the start point set-up, then one round per cell pass
// in a ring of NUM_CELLS iteration cells (registered products, then add and
// bound test), then the pass to the ring end and the result register;
// a point that escapes leaves the ring sooner.
// One pixel at a time: busy falls with the strobe, and a start seen while
// the strobe is high is taken. The receiver cannot stall. Synchronous
// active-low reset clears control state and loads the register defaults.
`default_nettype none

module mandelbrot_pixel_classifier import mpc_pkg::*; #(
    parameter int FRAME_WIDTH   = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT  = FRAME_HEIGHT_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration writes
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COORD_W-1:0]   i_cfg_data,
    // pixel command
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [PIX_W-1:0]     i_pixel_column,
    input  wire logic [PIX_W-1:0]     i_pixel_row,
    // result beat
    output logic                      o_valid,
    output logic [PIX_W-1:0]          o_out_column,
    output logic [PIX_W-1:0]          o_out_row,
    output logic                      o_pixel_color
);

    logic [COORD_W-1:0] r_center_x;
    logic [COORD_W-1:0] r_center_y;
    logic [SCALE_W-1:0] r_scale_w;
    logic [SCALE_W-1:0] r_scale_h;
    logic [ITER_W-1:0]  r_max_iter;

    logic               r_busy;
    logic [PIX_W-1:0]   r_col;
    logic [PIX_W-1:0]   r_row;
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_col;
    logic [PIX_W-1:0]   r_out_row;
    logic               r_out_color;

    logic               w_accept;
    logic               w_cx_valid;
    logic               w_cy_valid;
    logic [COORD_W-1:0] w_cx;
    logic [COORD_W-1:0] w_cy;
    logic               w_finish;
    t_token             w_inject;
    t_token             w_feedback;
    t_token             w_ring [NUM_CELLS+1];

    assign w_accept = start && !r_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= CENTER_X_RST;
            r_center_y <= CENTER_Y_RST;
            r_scale_w  <= SCALE_W_RST;
            r_scale_h  <= SCALE_H_RST;
            r_max_iter <= MAX_ITER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_SCALE_W:  r_scale_w  <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_H:  r_scale_h  <= i_cfg_data[SCALE_W-1:0];
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // start point for both axes
    mpc_coord #(
        .SIZE (FRAME_WIDTH)
    ) u_coord_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_coord  (i_pixel_column),
        .i_center (r_center_x),
        .i_scale  (r_scale_w),
        .o_valid  (w_cx_valid),
        .o_c      (w_cx)
    );

    mpc_coord #(
        .SIZE (FRAME_HEIGHT)
    ) u_coord_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_coord  (i_pixel_row),
        .i_center (r_center_y),
        .i_scale  (r_scale_h),
        .o_valid  (w_cy_valid),
        .o_c      (w_cy)
    );

    // ring entry: a new point, or the token coming round again
    always_comb begin
        w_inject       = '0;
        w_inject.valid = w_cx_valid && w_cy_valid;
        w_inject.rem   = r_max_iter;
        w_inject.cx    = w_cx;
        w_inject.cy    = w_cy;

        w_feedback       = w_ring[NUM_CELLS];
        w_feedback.valid = w_ring[NUM_CELLS].valid && !w_ring[NUM_CELLS].done;
    end

    assign w_ring[0] = w_inject.valid ? w_inject : w_feedback;
    assign w_finish  = w_ring[NUM_CELLS].valid && w_ring[NUM_CELLS].done;

    // ring of iteration cells
    for (genvar gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
        mpc_cell #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_ring[gi]),
            .o_tok   (w_ring[gi+1])
        );
    end

    // command tracking and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_finish;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_col <= i_pixel_column;
            r_row <= i_pixel_row;
        end
        if (w_finish) begin
            r_out_col   <= r_col;
            r_out_row   <= r_row;
            r_out_color <= w_ring[NUM_CELLS].color;
        end
    end

    assign busy          = r_busy;
    assign o_valid       = r_out_valid;
    assign o_out_column  = r_out_col;
    assign o_out_row     = r_out_row;
    assign o_pixel_color = r_out_color;

endmodule

`default_nettype wire

FILE: dv/mpc_checker.sv
// Checker for the Mandelbrot pixel classifier: tracks register writes, predicts
// the colour of every accepted pixel and compares each result beat in order.
// Depends on mpc_pkg.
`timescale 1ns / 100ps

module mpc_checker import mpc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COORD_W-1:0]   i_cfg_data,
    input  wire logic                 i_start,
    input  wire logic                 i_busy,
    input  wire logic [PIX_W-1:0]     i_pixel_column,
    input  wire logic [PIX_W-1:0]     i_pixel_row,
    input  wire logic                 i_valid,
    input  wire logic [PIX_W-1:0]     i_out_column,
    input  wire logic [PIX_W-1:0]     i_out_row,
    input  wire logic                 i_pixel_color,
    output int                        o_fail_count,
    output int                        o_pending
);

    // |z|^2 bound, 4.0 in the fixed-point format
    localparam longint ESCAPE_BOUND = longint'(4) << FRACTION_BITS_DEF;

    typedef struct {
        logic [PIX_W-1:0] column;
        logic [PIX_W-1:0] row;
        logic             color;
    } t_pixel_colour;

    // shadow copy of the view registers
    logic [COORD_W-1:0] view_cx  = CENTER_X_RST;
    logic [COORD_W-1:0] view_cy  = CENTER_Y_RST;
    logic [SCALE_W-1:0] view_sw  = SCALE_W_RST;
    logic [SCALE_W-1:0] view_sh  = SCALE_H_RST;
    logic [ITER_W-1:0]  view_its = MAX_ITER_RST;

    t_pixel_colour colours_due[$];
    t_pixel_colour due;
    int            mismatches = 0;

    // Start point along one axis, 32-bit wrap throughout
    function automatic logic [COORD_W-1:0] axis_start(input logic [COORD_W-1:0] centre,
                                                      input logic [PIX_W-1:0] pos,
                                                      input int unsigned span,
                                                      input logic [SCALE_W-1:0] step);
        logic [COORD_W-1:0] frac;
        frac = ({{(COORD_W-PIX_W){1'b0}}, pos} << COORD_SHIFT) / span;
        return centre + (frac - COORD_BIAS) * {{(COORD_W-SCALE_W){1'b0}}, step};
    endfunction

    // Escape-time colour of one pixel under the current view
    function automatic logic pixel_colour(input logic [PIX_W-1:0] col,
                                          input logic [PIX_W-1:0] row);
        longint cx, cy, x, y, xx, yy, xy;
        logic signed [COORD_W-1:0] nx, ny;
        int unsigned round;
        cx = longint'(signed'(axis_start(view_cx, col, FRAME_WIDTH_DEF, view_sw)));
        cy = longint'(signed'(axis_start(view_cy, row, FRAME_HEIGHT_DEF, view_sh)));
        x = 0;
        y = 0;
        for (round = 0; round < view_its; round++) begin
            xx = (x * x) >>> FRACTION_BITS_DEF;
            yy = (y * y) >>> FRACTION_BITS_DEF;
            xy = (x * y) >>> FRACTION_BITS_DEF;
            if (xx + yy > ESCAPE_BOUND)
                return COLOR_WHITE;
            // doubled cross term is kept exact, then wrapped with cy
            nx = COORD_W'(xx - yy + cx);
            ny = COORD_W'(2 * xy + cy);
            x = longint'(nx);
            y = longint'(ny);
        end
        return COLOR_BLACK;
    endfunction

    // Register shadow, prediction on accept, in-order compare on result beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            view_cx  <= CENTER_X_RST;
            view_cy  <= CENTER_Y_RST;
            view_sw  <= SCALE_W_RST;
            view_sh  <= SCALE_H_RST;
            view_its <= MAX_ITER_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CENTER_X: view_cx  <= i_cfg_data;
                    CFG_CENTER_Y: view_cy  <= i_cfg_data;
                    CFG_SCALE_W:  view_sw  <= i_cfg_data[SCALE_W-1:0];
                    CFG_SCALE_H:  view_sh  <= i_cfg_data[SCALE_W-1:0];
                    CFG_MAX_ITER: view_its <= i_cfg_data[ITER_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                due.column = i_pixel_column;
                due.row    = i_pixel_row;
                due.color  = pixel_colour(i_pixel_column, i_pixel_row);
                colours_due.push_back(due);
            end
            if (i_valid) begin
                if (colours_due.size() == 0) begin
                    $error("result beat with no pixel outstanding: column %0d row %0d",
                           i_out_column, i_out_row);
                    mismatches++;
                end else begin
                    due = colours_due.pop_front();
                    if (i_out_column !== due.column) begin
                        $error("out_column: expected %0d, actual %0d", due.column,
                               i_out_column);
                        mismatches++;
                    end
                    if (i_out_row !== due.row) begin
                        $error("out_row: expected %0d, actual %0d", due.row, i_out_row);
                        mismatches++;
                    end
                    if (i_pixel_color !== due.color) begin
                        $error("pixel_color: expected %0d, actual %0d", due.color,
                               i_pixel_color);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= colours_due.size();
    end

endmodule

FILE: dv/tb.sv
// Top of the Mandelbrot pixel classifier testbench: clock, reset, view
// register writes and pixel stimulus, plus the verdict. Depends on mpc_pkg,
// mandelbrot_pixel_classifier and mpc_checker.
`timescale 1ns / 100ps

module tb import mpc_pkg::*;;

    localparam int ITEM_TARGET  = 1650;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 2 * 255 + 16;
    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_MAX_ITER + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = {CFG_IDX_W{1'b1}};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COORD_W-1:0]   i_cfg_data;
    logic                 start;
    logic                 busy;
    logic [PIX_W-1:0]     i_pixel_column;
    logic [PIX_W-1:0]     i_pixel_row;
    logic                 o_valid;
    logic [PIX_W-1:0]     o_out_column;
    logic [PIX_W-1:0]     o_out_row;
    logic                 o_pixel_color;

    int chk_fail_count;
    int chk_pending;
    int cycles     = 0;
    int pixels_in  = 0;
    bit idle_gaps  = 1'b0;

    mandelbrot_pixel_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .o_valid        (o_valid),
        .o_out_column   (o_out_column),
        .o_out_row      (o_out_row),
        .o_pixel_color  (o_pixel_color)
    );

    mpc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start        (start),
        .i_busy         (busy),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .i_valid        (o_valid),
        .i_out_column   (o_out_column),
        .i_out_row      (o_out_row),
        .i_pixel_color  (o_pixel_color),
        .o_fail_count   (chk_fail_count),
        .o_pending      (chk_pending)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One register write; the caller drops the enable after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Drain the block, then load a whole view; spare index written last
    task automatic set_view(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                            input logic [SCALE_W-1:0] sw, input logic [SCALE_W-1:0] sh,
                            input logic [ITER_W-1:0] its);
        logic [COORD_W-1:0]   junk;
        logic [CFG_IDX_W-1:0] spare;
        junk  = $urandom;
        spare = CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST));
        start <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0 || busy)
            @(posedge i_clk);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_SCALE_W, {junk[31:20], sw});
        write_reg(CFG_SCALE_H, {junk[11:0], sh});
        write_reg(CFG_MAX_ITER, {junk[23:0], its});
        write_reg(spare, ~junk);
        i_cfg_we <= 1'b0;
    endtask

    // Present one pixel until taken, then maybe idle for a while
    task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
        int gap;
        int pick;
        start          <= 1'b1;
        i_pixel_column <= col;
        i_pixel_row    <= row;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pixels_in++;
        gap  = 0;
        pick = $urandom_range(0, 99);
        if (idle_gaps && pick >= 55)
            gap = (pick < 90) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [COORD_W-1:0] vcx, vcy;
        logic [SCALE_W-1:0] vsw, vsh;
        logic [ITER_W-1:0]  vits;
        int                 burst;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_CENTER_X;
        i_cfg_data     = '0;
        start          = 1'b0;
        i_pixel_column = '0;
        i_pixel_row    = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset view: frame corners, mid frame, bit patterns, rows past the frame
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd767);
        send_pixel(10'd512, 10'd384);
        send_pixel(10'h2AA, 10'h155);
        send_pixel(10'h155, 10'h2AA);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd768);

        // Zero rounds with extreme centres and scales: always black
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 20'hFFFFF, 20'hFFFFF, 8'd0);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);

        // c = 0 held for the full 255 rounds
        set_view(32'd0, 32'd0, 20'd0, 20'd0, 8'd255);
        send_pixel(10'd300, 10'd200);

        // c = -0.75 + 0.1i: slow escape through many doubled cross terms
        set_view(-32'sd201326592, 32'sd26843546, 20'd0, 20'd0, 8'd255);
        send_pixel(10'd640, 10'd100);

        // Opposite extreme centres, escape on the second round
        set_view(32'h7FFF_FFFF, 32'h8000_0000, 20'd0, 20'd0, 8'd2);
        send_pixel(10'd1023, 10'd767);
        send_pixel(10'd1, 10'd1);

        // Random views, mostly around the set, some fully random
        while (pixels_in < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                vcx  = $urandom;
                vcy  = $urandom;
                vsw  = SCALE_W'($urandom);
                vsh  = SCALE_W'($urandom);
                vits = ITER_W'($urandom);
            end else begin
                vcx = $urandom_range(0, 671088640) - 32'd536870912;
                vcy = $urandom_range(0, 536870912) - 32'd268435456;
                vsw = SCALE_W'($urandom_range(0, 786432) >> $urandom_range(0, 14));
                vsh = SCALE_W'($urandom_range(0, 524288) >> $urandom_range(0, 14));
                case ($urandom_range(0, 19))
                    0:       vits = 8'd0;
                    1:       vits = ITER_W'($urandom_range(121, 255));
                    2, 3, 4: vits = ITER_W'($urandom_range(41, 120));
                    default: vits = ITER_W'($urandom_range(1, 40));
                endcase
            end
            set_view(vcx, vcy, vsw, vsh, vits);
            idle_gaps = ($urandom_range(0, 3) != 0);
            burst     = $urandom_range(40, 160);
            if (burst > ITEM_TARGET - pixels_in)
                burst = ITEM_TARGET - pixels_in;
            repeat (burst) begin
                send_pixel(PIX_W'($urandom_range(0, 1023)),
                           PIX_W'(($urandom_range(0, 9) == 0) ? $urandom_range(768, 1023)
                                                              : $urandom_range(0, 767)));
            end
        end

        // Drain and verdict
        start <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (chk_fail_count == 0 && chk_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
